### src/hbp_pkg.sv
// Shared types and constants of the Huffman bit packer.
// Holds the input and output item structs and the code table entry layout.
// Depends on nothing.
package hbp_pkg;

    localparam int CODE_W = 32;
    localparam int LEN_W  = 6;
    localparam int BUF_W  = CODE_W + 8;

    localparam logic [1:0] KIND_LOAD   = 2'd0;
    localparam logic [1:0] KIND_ENCODE = 2'd1;
    localparam logic [1:0] KIND_FINISH = 2'd2;

    typedef struct packed {
        logic [1:0]        kind;
        logic [7:0]        symbol;
        logic [CODE_W-1:0] code_bits;
        logic [LEN_W-1:0]  code_len;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_trailer;
        logic       last;
    } t_out_item;

    typedef struct packed {
        logic [LEN_W-1:0]  code_len;
        logic [CODE_W-1:0] code_bits;
    } t_entry;

endpackage

### src/hbp_code_table.sv
// Code table of the Huffman bit packer: one entry per symbol.
// Synchronous memory, one write port and one read port, read data registered.
// Depends on hbp_pkg for the entry layout.
module hbp_code_table import hbp_pkg::*; #(
    parameter int SYMBOL_COUNT = 256,
    parameter int ADDR_W       = 8
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  t_entry            i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output t_entry            o_rd_data
);

    t_entry r_mem [SYMBOL_COUNT];
    t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### src/huffman_bit_packer.sv
// Huffman encoder back end: code table lookup and MSB-first byte packer.
// Uses hbp_pkg for item types and hbp_code_table for the symbol table.
//
//  channel | ports                       | moves
//  input   | i_in_valid, o_in_ready, i_in  | load, encode or finish item
//  output  | o_out_valid, i_out_ready, o_out | one packed or trailer byte
//
// A load item writes the table. An encode item reads the table through its
// registered read port, then enters the packer, which sends one byte per
// cycle through the output register while the output is ready; a finish
// item sends four or five bytes. A new item can enter the packer as the last
// byte of the one before it leaves. Reset is synchronous; the table is not cleared.
// A stalled output holds the packer, which in turn holds the lookup stage.
module huffman_bit_packer import hbp_pkg::*; #(
    parameter int SYMBOL_COUNT = 256,
    parameter int MAX_CODE_LEN = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out
);

    localparam int ADDR_W    = $clog2(SYMBOL_COUNT);
    localparam int LEN_LIMIT = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;

    // Lookup stage.
    logic   r_s1_valid;
    logic   r_s1_fin;
    t_entry w_rd_data;

    // Packer: r_buf holds the bytes still to send, left aligned; once they
    // are gone, its top bits hold the pending code bits.
    logic [BUF_W-1:0]  r_buf, n_buf;
    logic [2:0]        r_left, n_left;
    logic [2:0]        r_pc, n_pc;
    logic [CODE_W-1:0] r_total, n_total;
    logic              r_fin;

    logic      r_out_valid;
    t_out_item r_out;

    logic              w_acc, w_in_range, w_emit, w_free, w_go;
    logic [LEN_W-1:0]  w_len_sat;
    logic [BUF_W-1:0]  w_cur_buf, w_ins;
    logic [CODE_W-1:0] w_code_left;
    logic [5:0]        w_sum;
    t_entry            w_wr_data;

    assign w_in_range = {1'b0, i_in.symbol} < 9'(SYMBOL_COUNT);
    assign w_emit     = (r_left != 3'd0) && (!r_out_valid || i_out_ready);
    assign w_free     = (r_left == 3'd0) || ((r_left == 3'd1) && w_emit);
    assign w_go       = r_s1_valid && w_free;
    assign o_in_ready = !r_s1_valid || w_go;
    assign w_acc      = i_in_valid && o_in_ready;

    assign w_len_sat = (i_in.code_len > LEN_W'(LEN_LIMIT)) ? LEN_W'(LEN_LIMIT)
                                                           : i_in.code_len;
    assign w_wr_data = '{code_len: w_len_sat, code_bits: i_in.code_bits};

    hbp_code_table #(
        .SYMBOL_COUNT(SYMBOL_COUNT),
        .ADDR_W      (ADDR_W)
    ) u_table (
        .i_clk    (i_clk),
        .i_wr_en  (w_acc && (i_in.kind == KIND_LOAD) && w_in_range),
        .i_wr_addr(i_in.symbol[ADDR_W-1:0]),
        .i_wr_data(w_wr_data),
        .i_rd_en  (w_acc && (i_in.kind == KIND_ENCODE) && w_in_range),
        .i_rd_addr(i_in.symbol[ADDR_W-1:0]),
        .o_rd_data(w_rd_data)
    );

    // The byte leaving in this cycle is already gone from the view of a new item.
    assign w_cur_buf   = (r_left != 3'd0) ? {r_buf[BUF_W-9:0], 8'h00} : r_buf;
    assign w_code_left = w_rd_data.code_bits << (LEN_W'(CODE_W) - w_rd_data.code_len);
    assign w_ins       = {w_code_left, 8'h00} >> r_pc;
    assign w_sum       = 6'(r_pc) + 6'(w_rd_data.code_len);

    always_comb begin
        n_buf   = r_buf;
        n_left  = r_left;
        n_pc    = r_pc;
        n_total = r_total;
        priority if (w_go && r_s1_fin) begin
            if (r_pc != 3'd0) begin
                n_buf  = {w_cur_buf[BUF_W-1:BUF_W-8], r_total[7:0], r_total[15:8],
                          r_total[23:16], r_total[31:24]};
                n_left = 3'd5;
            end else begin
                n_buf  = {r_total[7:0], r_total[15:8], r_total[23:16],
                          r_total[31:24], 8'h00};
                n_left = 3'd4;
            end
            n_pc    = 3'd0;
            n_total = '0;
        end else if (w_go) begin
            n_buf   = w_cur_buf | w_ins;
            n_left  = w_sum[5:3];
            n_pc    = w_sum[2:0];
            n_total = r_total + CODE_W'(w_rd_data.code_len);
        end else if (w_emit) begin
            n_buf  = w_cur_buf;
            n_left = r_left - 3'd1;
        end else begin
            n_left = r_left;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_buf       <= '0;
            r_left      <= 3'd0;
            r_pc        <= 3'd0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_acc) begin
                r_s1_valid <= (i_in.kind == KIND_FINISH)
                           || ((i_in.kind == KIND_ENCODE) && w_in_range);
            end else if (w_go) begin
                r_s1_valid <= 1'b0;
            end
            r_buf   <= n_buf;
            r_left  <= n_left;
            r_pc    <= n_pc;
            r_total <= n_total;
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_s1_fin <= (i_in.kind == KIND_FINISH);
        end
        if (w_go) begin
            r_fin <= r_s1_fin;
        end
        if (w_emit) begin
            r_out.out_byte   <= r_buf[BUF_W-1:BUF_W-8];
            r_out.is_trailer <= r_fin && (r_left <= 3'd4);
            r_out.last       <= (r_left == 3'd1);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Once all bytes are sent, only the pending bits may remain in the buffer.
    a_pending_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_left == 3'd0) |-> ((r_buf[BUF_W-9:0] == '0)
            && ((r_buf[BUF_W-1:BUF_W-8] & (8'hFF >> r_pc)) == 8'h00)))
        else $error("packer buffer holds bits beyond the pending count");

    a_finish_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_go && r_s1_fin) |=> ((r_pc == 3'd0) && (r_total == '0)))
        else $error("finish item did not restart the stream");

    a_encode_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_go && !r_s1_fin) |=> (r_left <= 3'd4))
        else $error("encode item produced more than four bytes");

endmodule

### tb/sv/tb_huffman_bit_packer.sv
// Self-checking testbench for huffman_bit_packer: code table loads, MSB-first byte
// packing, zero padding and the bit-count trailer, all under random flow control.
// Depends on hbp_pkg and the huffman_bit_packer RTL.
module tb_huffman_bit_packer import hbp_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          LEN_LIMIT   = 32;
    localparam int          CYCLE_LIMIT = 200000;
    localparam int          RANDOM_ITEMS = 370;
    localparam int          DRAIN_CYCLES = 20;
    localparam logic [1:0]  KIND_NONE   = 2'd3;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_ready;
    t_in_item  i_in        = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_item o_out;

    huffman_bit_packer DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    // Shadow of the packer state.
    t_entry      code_tbl [256];
    logic [7:0]  acc_bits;
    int          acc_cnt;
    logic [31:0] stream_bits;
    t_out_item   out_bytes_q [$];

    // Stimulus bookkeeping.
    t_in_item    stim_q [$];
    bit          loaded [256];
    logic [7:0]  loaded_syms [$];
    int          n_queued, n_accepted;
    int          n_load, n_encode, n_finish, n_ignored;
    int          n_bytes, n_trailer, n_errors;
    int          cycles;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Advance the shadow packer by one accepted item and append the bytes it emits.
    function automatic void shadow_pack(t_in_item it);
        t_entry      ent;
        int unsigned len;
        int          n0;
        n0 = out_bytes_q.size();
        case (it.kind)
            KIND_LOAD: begin
                len = it.code_len;
                if (len > LEN_LIMIT) len = LEN_LIMIT;
                code_tbl[it.symbol].code_bits = it.code_bits;
                code_tbl[it.symbol].code_len  = len[LEN_W-1:0];
            end
            KIND_ENCODE: begin
                ent = code_tbl[it.symbol];
                len = ent.code_len;
                if (len > LEN_LIMIT) len = LEN_LIMIT;
                for (int i = int'(len); i > 0; i--) begin
                    acc_bits = {acc_bits[6:0], ent.code_bits[i-1]};
                    acc_cnt++;
                    if (acc_cnt == 8) begin
                        out_bytes_q.push_back('{out_byte: acc_bits, is_trailer: 1'b0,
                                                last: 1'b0});
                        acc_bits = '0;
                        acc_cnt  = 0;
                    end
                end
                stream_bits = stream_bits + len;
            end
            KIND_FINISH: begin
                // The padded byte goes out even when every pending bit is zero.
                if (acc_cnt != 0)
                    out_bytes_q.push_back('{out_byte: 8'(acc_bits << (8 - acc_cnt)),
                                            is_trailer: 1'b0, last: 1'b0});
                for (int j = 0; j < 4; j++)
                    out_bytes_q.push_back('{out_byte: stream_bits[8*j +: 8],
                                            is_trailer: 1'b1, last: 1'b0});
                acc_bits    = '0;
                acc_cnt     = 0;
                stream_bits = '0;
            end
            default: ;
        endcase
        if (out_bytes_q.size() > n0)
            out_bytes_q[$].last = 1'b1;
    endfunction

    task automatic queue_item(logic [1:0] kind, logic [7:0] sym, logic [31:0] bits,
                              logic [5:0] len);
        stim_q.push_back('{kind: kind, symbol: sym, code_bits: bits, code_len: len});
        n_queued++;
        case (kind)
            KIND_LOAD: begin
                n_load++;
                if (!loaded[sym]) begin
                    loaded[sym] = 1'b1;
                    loaded_syms.push_back(sym);
                end
            end
            KIND_ENCODE: n_encode++;
            KIND_FINISH: n_finish++;
            default:     n_ignored++;
        endcase
    endtask

    // Encode only symbols whose table entry has been written.
    task automatic queue_encode();
        queue_item(KIND_ENCODE, loaded_syms[$urandom_range(0, loaded_syms.size() - 1)],
                   $urandom, 6'($urandom_range(0, 63)));
    endtask

    task automatic report_field(string name, logic [7:0] want, logic [7:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            n_errors++;
        end
    endtask

    initial begin
        int r;
        int counted;

        // Directed part: extreme lengths, empty and saturated codes, padding cases.
        queue_item(KIND_LOAD, 8'd0,   32'hFFFF_FFFF, 6'd32);
        queue_item(KIND_LOAD, 8'd255, 32'h0000_0000, 6'd1);
        queue_item(KIND_LOAD, 8'd1,   32'h0000_0005, 6'd3);
        queue_item(KIND_LOAD, 8'd2,   32'h0000_ABCD, 6'd0);
        queue_item(KIND_LOAD, 8'd3,   32'h8000_0001, 6'd63);
        queue_item(KIND_LOAD, 8'd4,   32'h7FFF_FFFE, 6'd40);
        queue_item(KIND_FINISH, 8'd0, 32'h0, 6'd0);
        queue_item(KIND_ENCODE, 8'd0, 32'h0, 6'd0);
        queue_item(KIND_FINISH, 8'd0, 32'h0, 6'd0);
        queue_item(KIND_ENCODE, 8'd255, 32'h0, 6'd0);
        queue_item(KIND_ENCODE, 8'd2, 32'h0, 6'd0);
        queue_item(KIND_FINISH, 8'd0, 32'h0, 6'd0);
        queue_item(KIND_ENCODE, 8'd1, 32'h0, 6'd0);
        queue_item(KIND_ENCODE, 8'd3, 32'h0, 6'd0);
        queue_item(KIND_ENCODE, 8'd4, 32'h0, 6'd0);
        queue_item(KIND_NONE, 8'hFF, 32'hFFFF_FFFF, 6'h3F);
        queue_item(KIND_LOAD, 8'd1, 32'h0000_00A5, 6'd8);
        queue_item(KIND_ENCODE, 8'd1, 32'h0, 6'd0);
        queue_item(KIND_ENCODE, 8'd255, 32'h0, 6'd0);
        queue_item(KIND_ENCODE, 8'd1, 32'h0, 6'd0);
        queue_item(KIND_FINISH, 8'hFF, 32'hFFFF_FFFF, 6'h3F);

        // Random part: mostly streams of encodes with occasional reloads, finishes and ignored items.
        for (int k = 0; k < 16; k++)
            queue_item(KIND_LOAD, 8'($urandom), $urandom, 6'($urandom_range(1, 12)));
        counted = 16;
        while (counted < RANDOM_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 10) begin
                queue_item(KIND_LOAD, 8'($urandom), $urandom,
                           6'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 63)
                                                          : $urandom_range(1, 12)));
                counted++;
            end else if (r < 85) begin
                queue_encode();
                counted++;
            end else if (r < 93) begin
                queue_item(KIND_FINISH, 8'($urandom), $urandom, 6'($urandom_range(0, 63)));
                counted++;
            end else begin
                queue_item(KIND_NONE, 8'($urandom), $urandom, 6'($urandom_range(0, 63)));
                counted++;
            end
        end
        queue_item(KIND_FINISH, 8'd0, 32'h0, 6'd0);

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (n_accepted < n_queued) @(posedge i_clk);
        while (out_bytes_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Ran %0d items: %0d loads, %0d encodes, %0d finishes, %0d ignored.",
                 n_queued, n_load, n_encode, n_finish, n_ignored);
        $display("Checked %0d output bytes, %0d of them trailer bytes.", n_bytes, n_trailer);
        if (n_errors == 0) begin
            $display("tb_huffman_bit_packer OK");
        end else begin
            $display("tb_huffman_bit_packer NOT OK");
        end
        $finish;
    end

    // Sender: bursts of back-to-back items separated by random gaps.
    int burst_left = 0;
    int gap_left   = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            acc_bits    = '0;
            acc_cnt     = 0;
            stream_bits = '0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                shadow_pack(i_in);
                n_accepted++;
            end
            if (!i_in_valid || o_in_ready) begin
                if (gap_left > 0 || stim_q.size() == 0) begin
                    if (gap_left > 0) gap_left--;
                    i_in_valid <= 1'b0;
                end else begin
                    i_in       <= stim_q.pop_front();
                    i_in_valid <= 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 20);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
            end
        end
    end

    // Receiver: changes between always ready, random stalls and a fixed pattern,
    // with one long hold-off that backs the block up into its input.
    int  rx_cyc    = 0;
    int  rx_mode   = 0;
    int  mode_left = 0;
    int  hold_left = 0;
    bit  hold_done = 1'b0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            rx_cyc++;
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (!hold_done && rx_cyc >= 200) begin
                hold_done = 1'b1;
                hold_left = 300;
                i_out_ready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    rx_mode   = $urandom_range(0, 2);
                    mode_left = $urandom_range(16, 80);
                end else begin
                    mode_left--;
                end
                case (rx_mode)
                    0:       i_out_ready <= 1'b1;
                    1:       i_out_ready <= ($urandom_range(0, 3) != 0);
                    default: i_out_ready <= (rx_cyc % 3 == 0);
                endcase
            end
        end
    end

    // Output check against the oldest predicted byte.
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (out_bytes_q.size() == 0) begin
                $display("%0t: unexpected item, expected none, actual %h/%b/%b", $time,
                         o_out.out_byte, o_out.is_trailer, o_out.last);
                n_errors++;
            end else begin
                want = out_bytes_q.pop_front();
                report_field("out_byte", want.out_byte, o_out.out_byte);
                report_field("is_trailer", 8'(want.is_trailer), 8'(o_out.is_trailer));
                report_field("last", 8'(want.last), 8'(o_out.last));
                n_bytes++;
                if (want.is_trailer) n_trailer++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d of %0d items accepted.",
                     cycles, n_accepted, n_queued);
            $display("tb_huffman_bit_packer NOT OK");
            $finish;
        end
    end

endmodule

### files.f
src/hbp_pkg.sv
src/hbp_code_table.sv
src/huffman_bit_packer.sv
tb/sv/tb_huffman_bit_packer.sv
